// File: rtl/nearest_neighbor_tour_length_top_assert.svh
// Assertion macros for the tour length block
`ifndef NEAREST_NEIGHBOR_TOUR_LENGTH_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_TOUR_LENGTH_TOP_ASSERT_SVH
`define NNTL_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("check failed");
`define NNTL_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("check failed");
`endif

// File: rtl/nntl_pkg.sv
// ---------------------------------------------------------------------------
// nntl_pkg
// Types and constants for the nearest neighbor tour length block.
// ---------------------------------------------------------------------------
`default_nettype none
package nntl_pkg;
	localparam int MAX_CITIES = 1024;
	localparam int FRAC_BITS  = 8;
	localparam int IDX_W      = $clog2(MAX_CITIES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int SQ_W       = 34;
	localparam int TOT_W      = 36;
	localparam int ROOT_STEPS = 17 + FRAC_BITS;
	localparam int RAD_W      = SQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W     = ROOT_STEPS;
	localparam int STEP_W     = $clog2(ROOT_STEPS + 1);

	typedef struct packed {
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic               last_city;
	} in_item_t;

	typedef struct packed {
		logic [TOT_W-1:0] tour_length;
		logic [10:0]      cities_used;
		logic             cities_dropped;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_LOAD, ST_CLEAR, ST_HERE, ST_SCAN, ST_DRAIN, ST_PICK,
		ST_ROOT, ST_ROOTW, ST_HOME, ST_HOMEW, ST_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [SQ_W-1:0]  square;
	} root_req_t;

	typedef struct packed {
		logic              busy;
		logic [ROOT_W-1:0] root;
	} root_rsp_t;
endpackage
`default_nettype wire

// File: rtl/nearest_neighbor_tour_length_top.sv
// ---------------------------------------------------------------------------
// nearest_neighbor_tour_length_top
// Stores city coordinates, then walks a greedy nearest neighbor tour and
// returns the closed tour length.
// ---------------------------------------------------------------------------
// channel   signals                     payload
// in        in_valid / in_ready         in_item_t
// out       out_valid / out_ready       out_item_t
// A city without the last mark is stored and in_ready stays high. The
// closing item runs the tour: it clears the visited marks, then per step
// scans the cities through the coordinate memory read port and takes a
// square root. Output stays until taken; no item accepted meanwhile.
// Reset clears control only; coordinate memory is not cleared.
`default_nettype none
module nearest_neighbor_tour_length_top
	import nntl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);
	logic [31:0] xy_mem [MAX_CITIES];
	logic        vis_mem [MAX_CITIES];

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             drop_q;
	logic [IDX_W-1:0] here_q, best_q, scan_q, idx_s1, idx_s2;
	logic             v_s1, v_s2, vis_s2;
	logic [31:0]      rd_s2;
	logic [SQ_W-1:0]  sq_s2;
	logic             seen_s2;
	logic [31:0]      xy_s2;
	logic [31:0]      best_xy_q;
	logic [SQ_W-1:0]  best_sq_q;
	logic             found_q;
	logic [TOT_W-1:0] total_q;
	logic [CNT_W-1:0] step_q;
	logic signed [15:0] hx_q, hy_q;
	logic             hload_q;
	root_req_t        rreq;
	root_rsp_t        rrsp;
	logic             scan_last;
	logic signed [16:0] dx, dy;
	logic [SQ_W-1:0]  d2;
	logic [TOT_W:0]   sum;
	logic             mem_we, vis_we;
	logic [IDX_W-1:0] vis_wa;
	logic             vis_wd;
	logic             home_rd_q;
	logic signed [15:0] zx_q, zy_q, c0x_q, c0y_q;
	logic signed [16:0] hdx, hdy;
	logic [SQ_W-1:0]  home_sq_q;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_OUT);
	assign out_item.tour_length    = total_q;
	assign out_item.cities_used    = count_q;
	assign out_item.cities_dropped = drop_q;
	assign scan_last = ({1'b0, scan_q} == count_q - 1'b1);

	assign mem_we = in_valid && in_ready && (count_q < CNT_W'(MAX_CITIES));

	always_ff @(posedge clk) begin
		if (mem_we) xy_mem[count_q[IDX_W-1:0]] <= {in_item.coord_x, in_item.coord_y};
		rd_s2  <= xy_mem[hload_q ? here_q : scan_q];
		vis_s2 <= vis_mem[scan_q];
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		sq_s2   <= d2;
		seen_s2 <= vis_s2;
		xy_s2   <= rd_s2;
	end

	assign dx = 17'(signed'(rd_s2[31:16])) - 17'(hx_q);
	assign dy = 17'(signed'(rd_s2[15:0])) - 17'(hy_q);
	assign d2 = SQ_W'(dx * dx) + SQ_W'(dy * dy);
	assign sum = {1'b0, total_q} + (TOT_W+1)'(rrsp.root);

	always_comb begin
		state_d = state_q;
		rreq = '0;
		vis_we = 1'b0;
		vis_wa = scan_q;
		vis_wd = 1'b0;
		unique case (state_q)
			ST_LOAD: if (in_valid && in_item.last_city) state_d = ST_CLEAR;
			ST_CLEAR: begin
				vis_we = 1'b1;
				vis_wd = (scan_q == '0);
				if (scan_last) state_d = ST_HERE;
			end
			ST_HERE: state_d = (step_q >= count_q) ? ST_HOME : ST_SCAN;
			ST_SCAN: if (scan_last) state_d = ST_DRAIN;
			ST_DRAIN: if (!v_s1 && !v_s2) state_d = ST_PICK;
			ST_PICK: begin
				rreq.start = 1'b1;
				rreq.square = best_sq_q;
				vis_we = 1'b1;
				vis_wa = best_q;
				vis_wd = 1'b1;
				state_d = ST_ROOT;
			end
			ST_ROOT: state_d = ST_ROOTW;
			ST_ROOTW: if (!rrsp.busy) state_d = ST_HERE;
			ST_HOME: begin
				rreq.start = 1'b1;
				rreq.square = home_sq_q;
				state_d = ST_HOMEW;
			end
			ST_HOMEW: if (!rrsp.busy) state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
			scan_q  <= '0;
			here_q  <= '0;
			best_q  <= '0;
			best_xy_q <= '0;
			step_q  <= '0;
			total_q <= '0;
			found_q <= 1'b0;
			best_sq_q <= '1;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			idx_s1 <= '0;
			idx_s2 <= '0;
			hload_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= (state_q == ST_SCAN) && !hload_q;
			v_s2 <= v_s1;
			idx_s1 <= scan_q;
			idx_s2 <= idx_s1;
			unique case (state_q)
				ST_LOAD: begin
					scan_q <= '0;
					if (in_valid) begin
						if (count_q < CNT_W'(MAX_CITIES)) count_q <= count_q + 1'b1;
						else drop_q <= 1'b1;
					end
				end
				ST_CLEAR: begin
					scan_q <= scan_last ? '0 : scan_q + 1'b1;
					here_q <= '0;
					step_q <= CNT_W'(1);
					total_q <= '0;
					hload_q <= 1'b1;
				end
				ST_HERE: begin
					scan_q <= '0;
					found_q <= 1'b0;
					best_sq_q <= '1;
					best_q <= '0;
					hload_q <= 1'b1;
				end
				ST_SCAN: begin
					if (hload_q) hload_q <= 1'b0;
					else if (!scan_last) scan_q <= scan_q + 1'b1;
				end
				default: ;
			endcase
			if (v_s2 && !seen_s2 && (!found_q || sq_s2 < best_sq_q)) begin
				found_q <= 1'b1;
				best_sq_q <= sq_s2;
				best_q <= idx_s2;
				best_xy_q <= xy_s2;
			end
			if (state_q == ST_PICK) begin
				here_q <= best_q;
				step_q <= step_q + 1'b1;
			end
			if ((state_q == ST_ROOTW || state_q == ST_HOMEW) && !rrsp.busy)
				total_q <= sum[TOT_W] ? '1 : sum[TOT_W-1:0];
			if (state_q == ST_OUT && out_ready) begin
				count_q <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	// Home leg: city 0 is captured on load, the current city on each pick.
	always_ff @(posedge clk) begin
		home_rd_q <= hload_q;
		if (home_rd_q && state_q == ST_SCAN) begin
			hx_q <= signed'(rd_s2[31:16]);
			hy_q <= signed'(rd_s2[15:0]);
		end
		if (mem_we && count_q == '0) begin
			c0x_q <= in_item.coord_x;
			c0y_q <= in_item.coord_y;
		end
		if (state_q == ST_CLEAR) begin
			zx_q <= c0x_q;
			zy_q <= c0y_q;
		end
		if (state_q == ST_PICK) begin
			zx_q <= signed'(best_xy_q[31:16]);
			zy_q <= signed'(best_xy_q[15:0]);
		end
	end

	assign hdx = 17'(zx_q) - 17'(c0x_q);
	assign hdy = 17'(zy_q) - 17'(c0y_q);

	always_ff @(posedge clk) begin
		home_sq_q <= SQ_W'(hdx * hdx) + SQ_W'(hdy * hdy);
	end

	nntl_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rreq),
		.rsp    (rrsp)
	);

	`include "nearest_neighbor_tour_length_top_assert.svh"

	`NNTL_ASSERT_IMPL(a_out_no_in, out_valid, !in_ready)
	`NNTL_ASSERT_IMPL(a_count_cap, 1'b1, count_q <= CNT_W'(MAX_CITIES))
	`NNTL_ASSERT_NEXT(a_root_busy, rreq.start, rrsp.busy)
endmodule
`default_nettype wire

// File: rtl/nntl_sqrt.sv
// ---------------------------------------------------------------------------
// nntl_sqrt
// Bit-pair integer square root of square * 4^FRAC_BITS, one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module nntl_sqrt
	import nntl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire root_req_t req,
	output root_rsp_t      rsp
);
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic [ROOT_W+1:0] rem_sh, trial;

	assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign rsp.busy = busy_q;
	assign rsp.root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_W'(ROOT_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STEP_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= {req.square, {(2*FRAC_BITS){1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// File: verif/nntl_checker.sv
// ---------------------------------------------------------------------------
// nntl_checker
// Watches both channels of the tour length block, predicts each closed tour
// with its own greedy walk over the accepted cities, and compares results.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module nntl_checker
	import nntl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire in_item_t  in_item,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire out_item_t out_item,
	output int             fail_count,
	output int             pending
);
	logic signed [15:0] city_x [MAX_CITIES];
	logic signed [15:0] city_y [MAX_CITIES];
	bit                 seen [MAX_CITIES];
	int                 city_cnt;
	bit                 dropped;
	out_item_t          tour_q [$];

	function automatic logic [SQ_W-1:0] dist_sq(int a, int b);
		longint dx, dy;
		dx = longint'(city_x[a]) - longint'(city_x[b]);
		dy = longint'(city_y[a]) - longint'(city_y[b]);
		return SQ_W'(dx * dx + dy * dy);
	endfunction

	function automatic longint leg_len(logic [SQ_W-1:0] d2);
		longint v, r;
		v = longint'(d2) << (2 * FRAC_BITS);
		r = longint'($floor($sqrt(real'(v))));
		while (r * r > v) r--;
		while ((r + 1) * (r + 1) <= v) r++;
		return r;
	endfunction

	function automatic out_item_t tour_of_set();
		out_item_t res;
		longint total, lim;
		logic [SQ_W-1:0] bsq, d;
		int here, best;
		bit found;
		lim = (longint'(1) << TOT_W) - 1;
		foreach (seen[i]) seen[i] = 0;
		total = 0;
		here = 0;
		seen[0] = 1;
		for (int s = 1; s < city_cnt; s++) begin
			found = 0;
			bsq = '1;
			best = 0;
			for (int i = 0; i < city_cnt; i++) begin
				if (seen[i]) continue;
				d = dist_sq(here, i);
				if (!found || d < bsq) begin
					found = 1;
					bsq = d;
					best = i;
				end
			end
			total += leg_len(bsq);
			if (total > lim) total = lim;
			here = best;
			seen[here] = 1;
		end
		total += leg_len(dist_sq(here, 0));
		if (total > lim) total = lim;
		res.tour_length = TOT_W'(total);
		res.cities_used = 11'(city_cnt);
		res.cities_dropped = dropped;
		return res;
	endfunction

	assign pending = tour_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			city_cnt = 0;
			dropped = 0;
			fail_count = 0;
			tour_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (tour_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", out_item);
				end else begin
					want = tour_q.pop_front();
					if (want.tour_length !== out_item.tour_length ||
						want.cities_used !== out_item.cities_used ||
						want.cities_dropped !== out_item.cities_dropped) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp len %0d used %0d drop %0d, got len %0d used %0d drop %0d",
								want.tour_length, want.cities_used, want.cities_dropped,
								out_item.tour_length, out_item.cities_used,
								out_item.cities_dropped);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (city_cnt < MAX_CITIES) begin
					city_x[city_cnt] = in_item.coord_x;
					city_y[city_cnt] = in_item.coord_y;
					city_cnt++;
				end else
					dropped = 1;
				if (in_item.last_city) begin
					tour_q = {tour_q, tour_of_set()};
					city_cnt = 0;
					dropped = 0;
				end
			end
		end
	end
endmodule

// File: verif/tb_nearest_neighbor_tour_length_top.sv
// ---------------------------------------------------------------------------
// tb_nearest_neighbor_tour_length_top
// Drives city sets into the tour length block with random gaps and output
// stalls (none in the calm phase); a checker beside the block predicts and compares each tour.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_nearest_neighbor_tour_length_top;
	import nntl_pkg::*;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 0;
	out_item_t out_item;
	int        fail_count;
	int        pending;
	bit        calm = 0;
	int        sent = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	nearest_neighbor_tour_length_top uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
		.out_item(out_item)
	);

	nntl_checker chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
		.out_item(out_item), .fail_count(fail_count), .pending(pending)
	);

	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= 33);

	task automatic send_city(logic signed [15:0] x, logic signed [15:0] y, logic last);
		while (!calm && $urandom_range(99) < 33) @(negedge clk);
		in_valid = 1;
		in_item = '{coord_x: x, coord_y: y, last_city: last};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid = 0;
		sent++;
	endtask

	task automatic rand_set(int n, int span);
		for (int i = 0; i < n; i++)
			send_city(16'($urandom_range(2 * span) - span),
				16'($urandom_range(2 * span) - span), i == n - 1);
	endtask

	initial begin
		#1000000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_city(16'sh1234, -16'sd77, 1);
		send_city(-16'sd32768, -16'sd32768, 0);
		send_city(16'sd32767, 16'sd32767, 1);
		send_city(16'sd32767, -16'sd32768, 0);
		send_city(-16'sd32768, 16'sd32767, 0);
		send_city(16'sd32767, 16'sd32767, 0);
		send_city(-16'sd32768, -16'sd32768, 1);
		send_city(0, 0, 0);
		send_city(3, 4, 0);
		send_city(-3, 4, 0);
		send_city(3, -4, 0);
		send_city(-3, -4, 1);
		send_city(5, 5, 0);
		send_city(5, 5, 1);
		send_city(16'hffff, 16'haaaa, 0);
		send_city(16'h5555, 16'h0000, 1);
		wait (pending == 0);
		repeat (40) @(negedge clk);
		calm = 1;
		rand_set(200, 32768);
		calm = 0;
		wait (pending == 0);
		repeat (40) @(negedge clk);
		while (sent < 580) begin
			case ($urandom_range(3))
				0: rand_set($urandom_range(1, 4), 4);
				1: rand_set($urandom_range(1, 12), 32768);
				2: rand_set($urandom_range(2, 30), 200);
				default: rand_set($urandom_range(1, 20), 32768);
			endcase
		end
		wait (pending == 0);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
